@@ sv/salru_pkg.sv @@
// ----------------------------------------------------------------------------
// Cache tag store package
// Sizes, register indexes, access codes and the per-set storage word shared
// by the set-associative LRU tag store.
// ----------------------------------------------------------------------------
package salru_pkg;

   // Geometry of the tag store.
   localparam int SETS   = 64;
   localparam int WAYS   = 4;
   localparam int SET_W  = $clog2(SETS);
   localparam int WAY_W  = $clog2(WAYS);
   localparam int RANK_W = $clog2(WAYS);

   // Field and register widths.
   localparam int ADDR_W     = 32;
   localparam int TAG_W      = 32;
   localparam int OFS_W      = 5;
   localparam int IDX_W      = 3;
   localparam int NWAY_W     = 3;
   localparam int POL_W      = 1;
   localparam int REFS_W     = 2;
   localparam int SHAMT_W    = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;
   localparam int RSP_DATA_W = 8;

   // Reset values of the configuration registers.
   localparam logic [OFS_W-1:0]  OFFSET_BITS_RST  = OFS_W'(4);
   localparam logic [IDX_W-1:0]  INDEX_BITS_RST   = IDX_W'(6);
   localparam logic [NWAY_W-1:0] WAYS_IN_USE_RST  = NWAY_W'(4);
   localparam logic [POL_W-1:0]  WRITE_POLICY_RST = POL_W'(0);

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET_BITS  = 2'd0,
      CSR_INDEX_BITS   = 2'd1,
      CSR_WAYS_IN_USE  = 2'd2,
      CSR_WRITE_POLICY = 2'd3
   } csr_index_type;

   // Access kinds and write policies.
   localparam logic ACTION_READ       = 1'b0;
   localparam logic ACTION_WRITE      = 1'b1;
   localparam logic POLICY_WRITE_THRU = 1'b0;
   localparam logic POLICY_WRITE_BACK = 1'b1;

   // Everything kept for one set: one memory word.
   typedef struct packed {
      logic [WAYS-1:0][TAG_W-1:0]  tag;
      logic [WAYS-1:0]             dirty;
      logic [WAYS-1:0]             valid;
      logic [WAYS-1:0][RANK_W-1:0] rank;
   } set_word_type;

   // Result of one access.
   typedef struct packed {
      logic [WAY_W-1:0]  way_used;
      logic              evicted_dirty;
      logic [REFS_W-1:0] memory_refs;
      logic              hit;
   } result_type;

   // Contents of a set that has never been written since reset.
   function automatic set_word_type reset_set_word();
      set_word_type word;
      word       = '0;
      for (int w = 0; w < WAYS; w++) begin
         word.rank[w] = RANK_W'(w);
      end
      return word;
   endfunction

endpackage

@@ sv/set_assoc_lru_cache_tag_store.sv @@
// ----------------------------------------------------------------------------
// Set-associative LRU cache tag store
// Looks up one access per beat, updates valid, dirty and LRU state of the set
// and reports hit, memory references, dirty eviction and the way used.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one access per beat: the byte address in
//   req_tdata and the access kind in req_tuser. The rsp channel returns one
//   result beat per access, in order. The csr port sets offset bits, index
//   bits, ways in use and write policy; write it only while the block is idle.
//   An access is split into tag, set and offset at acceptance, and the set
//   word is read from the set memory at the same edge. In the next cycle the
//   lookup, victim choice and LRU update run on that word; when the lookup
//   stage commits, the new word is written back and the result is loaded
//   into the output register, which drives the rsp channel. A new request
//   is accepted in every cycle while the result side keeps up; a write-back
//   to the set read by the following access is forwarded, so back-to-back
//   accesses to one set see the updated state. The single memory read port
//   sets this rate. If rsp_tready stays low, one result waits in the output
//   register, one access waits in the lookup stage and req_tready then
//   drops.
//   Reset is synchronous: it restores the register defaults and clears a
//   per-set written flag, so every set reads as all lines invalid with ranks
//   equal to the way number. No clearing pass runs.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tag_store
   import salru_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [ADDR_W-1:0]     req_tdata,   // [31:0] address
   input  logic                  req_tuser,   // [0] action (0 read, 1 write)
   // Result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [0] hit, [2:1] memory_refs,
                                              // [3] evicted_dirty,
                                              // [5:4] way_used, [7:6] zero
   // Configuration port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers
   logic [OFS_W-1:0]  offset_bits_ff;
   logic [IDX_W-1:0]  index_bits_ff;
   logic [NWAY_W-1:0] ways_in_use_ff;
   logic [POL_W-1:0]  write_policy_ff;

   // Set memory and per-set written flags
   set_word_type      set_mem [SETS];
   logic [SETS-1:0]   set_written_ff;

   // Lookup stage registers
   logic              s1_valid_ff;
   logic              s1_write_ff;
   logic [TAG_W-1:0]  s1_tag_ff;
   logic [SET_W-1:0]  s1_set_ff;
   set_word_type      mem_rd_ff;
   logic              s1_written_ff;
   logic              s1_bypass_ff;
   set_word_type      last_wr_ff;

   // Output register
   logic              rsp_valid_ff;
   result_type        rsp_data_ff;

   // Handshake and address split
   logic              accept;
   logic              commit;
   logic [IDX_W-1:0]  kb;
   logic [SET_W:0]    set_mask;
   logic [ADDR_W-1:0] addr_shift;
   logic [SHAMT_W-1:0] tag_shamt;
   logic [SET_W-1:0]  req_set;
   logic [TAG_W-1:0]  req_tag;

   // Lookup stage logic
   set_word_type      cur_word;
   set_word_type      new_word_in;
   result_type        result_in;
   logic [NWAY_W-1:0] nways;
   logic [WAYS-1:0]   in_use;
   logic [WAYS-1:0]   match;
   logic              hit;
   logic [WAY_W-1:0]  hit_way;
   logic              inv_found;
   logic [WAY_W-1:0]  inv_way;
   logic [WAY_W-1:0]  lru_way;
   logic [WAY_W-1:0]  victim;
   logic [WAY_W-1:0]  sel_way;
   logic              alloc;
   logic              touch;
   logic              evd;
   logic [RANK_W-1:0] old_rank;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff  <= OFFSET_BITS_RST;
         index_bits_ff   <= INDEX_BITS_RST;
         ways_in_use_ff  <= WAYS_IN_USE_RST;
         write_policy_ff <= WRITE_POLICY_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_OFFSET_BITS:  offset_bits_ff  <= csr_wdata[OFS_W-1:0];
            CSR_INDEX_BITS:   index_bits_ff   <= csr_wdata[IDX_W-1:0];
            CSR_WAYS_IN_USE:  ways_in_use_ff  <= csr_wdata[NWAY_W-1:0];
            CSR_WRITE_POLICY: write_policy_ff <= csr_wdata[POL_W-1:0];
            default: ;
         endcase
      end
   end

   // A beat moves on when the lookup stage is empty or hands its result on.
   assign commit     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || commit;
   assign accept     = req_tvalid && req_tready;

   // Split the address into set index and tag; index bits saturate to SET_W.
   always_comb begin
      kb         = (index_bits_ff > IDX_W'(SET_W)) ? IDX_W'(SET_W) : index_bits_ff;
      set_mask   = ((SET_W+1)'(1) << kb) - (SET_W+1)'(1);
      addr_shift = req_tdata >> offset_bits_ff;
      req_set    = addr_shift[SET_W-1:0] & set_mask[SET_W-1:0];
      tag_shamt  = SHAMT_W'(offset_bits_ff) + SHAMT_W'(kb);
      if (tag_shamt >= SHAMT_W'(ADDR_W)) begin
         req_tag = '0;
      end else begin
         req_tag = req_tdata >> tag_shamt;
      end
   end

   // Set memory: read at acceptance, written when the lookup stage commits.
   always_ff @(posedge clock) begin
      if (accept) begin
         mem_rd_ff <= set_mem[req_set];
      end
      if (commit) begin
         set_mem[s1_set_ff] <= new_word_in;
      end
   end

   // Written flags stand in for clearing the memory at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         set_written_ff <= '0;
      end else if (commit) begin
         set_written_ff[s1_set_ff] <= 1'b1;
      end
   end

   // Lookup stage control.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (commit) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // Lookup stage payload, with forwarding of a same-cycle write to the set.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_write_ff   <= req_tuser;
         s1_tag_ff     <= req_tag;
         s1_set_ff     <= req_set;
         s1_written_ff <= set_written_ff[req_set];
         s1_bypass_ff  <= commit && (s1_set_ff == req_set);
      end
      if (commit) begin
         last_wr_ff <= new_word_in;
      end
   end

   // Current contents of the set under lookup.
   always_comb begin
      if (s1_bypass_ff) begin
         cur_word = last_wr_ff;
      end else if (s1_written_ff) begin
         cur_word = mem_rd_ff;
      end else begin
         cur_word = reset_set_word();
      end
   end

   // Ways in use: zero counts as one, values above WAYS saturate.
   always_comb begin
      if (ways_in_use_ff == '0) begin
         nways = NWAY_W'(1);
      end else if (ways_in_use_ff > NWAY_W'(WAYS)) begin
         nways = NWAY_W'(WAYS);
      end else begin
         nways = ways_in_use_ff;
      end
      for (int w = 0; w < WAYS; w++) begin
         in_use[w] = NWAY_W'(w) < nways;
      end
   end

   // Tag compare; the lowest matching way wins.
   always_comb begin
      hit_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         match[w] = in_use[w] && cur_word.valid[w] && (cur_word.tag[w] == s1_tag_ff);
      end
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit_way = WAY_W'(w);
         end
      end
      hit = |match;
   end

   // Victim: lowest invalid way in use, else the in-use way of highest rank.
   always_comb begin
      inv_found = 1'b0;
      inv_way   = '0;
      lru_way   = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (in_use[w] && !cur_word.valid[w]) begin
            inv_found = 1'b1;
            inv_way   = WAY_W'(w);
         end
      end
      for (int w = 1; w < WAYS; w++) begin
         if (in_use[w] && (cur_word.rank[w] > cur_word.rank[lru_way])) begin
            lru_way = WAY_W'(w);
         end
      end
      victim = inv_found ? inv_way : lru_way;
   end

   // Policy decision, new set word and result.
   always_comb begin
      alloc    = !hit && !(s1_write_ff == ACTION_WRITE &&
                           write_policy_ff == POLICY_WRITE_THRU);
      touch    = hit || alloc;
      sel_way  = hit ? hit_way : victim;
      evd      = alloc && cur_word.valid[victim] && cur_word.dirty[victim];
      old_rank = cur_word.rank[sel_way];

      new_word_in = cur_word;
      if (hit && s1_write_ff == ACTION_WRITE && write_policy_ff == POLICY_WRITE_BACK) begin
         new_word_in.dirty[sel_way] = 1'b1;
      end
      if (alloc) begin
         new_word_in.tag[sel_way]   = s1_tag_ff;
         new_word_in.valid[sel_way] = 1'b1;
         new_word_in.dirty[sel_way] = s1_write_ff;
      end
      // Move the touched way to the front of the LRU order.
      if (touch) begin
         for (int w = 0; w < WAYS; w++) begin
            if (cur_word.rank[w] < old_rank) begin
               new_word_in.rank[w] = cur_word.rank[w] + RANK_W'(1);
            end
         end
         new_word_in.rank[sel_way] = '0;
      end

      result_in.hit           = hit;
      result_in.evicted_dirty = evd;
      result_in.way_used      = touch ? sel_way : '0;
      if (alloc) begin
         result_in.memory_refs = REFS_W'(1) + REFS_W'(evd);
      end else if (s1_write_ff == ACTION_WRITE && write_policy_ff == POLICY_WRITE_THRU) begin
         result_in.memory_refs = REFS_W'(1);
      end else begin
         result_in.memory_refs = '0;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_data_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_data_ff);

   // A held result and a held lookup must stop new requests.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request taken while both stages are stalled");

   // A dirty eviction always costs the fill and the write-back.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[3]) |-> (rsp_tdata[2:1] == 2'd2 && !rsp_tdata[0]))
      else $error("dirty eviction with wrong reference count or on a hit");

   // A committed result appears in the output register at the next edge.
   assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_tvalid)
      else $error("committed lookup produced no result");

endmodule

@@ tb/set_assoc_lru_cache_tag_store_tb.sv @@
// ----------------------------------------------------------------------------
// Set-associative LRU cache tag store testbench
// Streams read and write accesses into the tag store under a series of
// geometry and write-policy settings. Idle cycles on both sides are drawn at
// random. A scoreboard keeps its own copy of the tags, valid, dirty and LRU
// ranks and compares every result beat with its prediction, field by field.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tag_store_tb
   import salru_pkg::*;
();

   localparam int CYCLE_LIMIT = 100000;
   localparam int LINES       = SETS * WAYS;

   // Shadow of the tag store: predicts one result per access and checks the
   // result beats against those predictions in order.
   class tag_store_scoreboard;
      logic [OFS_W-1:0]  offset_bits;
      logic [IDX_W-1:0]  index_bits;
      logic [NWAY_W-1:0] ways_in_use;
      logic              write_policy;
      logic [TAG_W-1:0]  line_tag [LINES];
      bit                line_valid [LINES];
      bit                line_dirty [LINES];
      int                line_rank [LINES];
      result_type        expected_results[$];
      int errors, reads, writes, hits, dirty_evictions, mem_refs, results_seen;

      function new();
         offset_bits  = OFFSET_BITS_RST;
         index_bits   = INDEX_BITS_RST;
         ways_in_use  = WAYS_IN_USE_RST;
         write_policy = WRITE_POLICY_RST;
         for (int i = 0; i < LINES; i++) begin
            line_tag[i]   = '0;
            line_valid[i] = 1'b0;
            line_dirty[i] = 1'b0;
            line_rank[i]  = i % WAYS;
         end
      endfunction

      function void set_reg(csr_index_type idx, int value);
         case (idx)
            CSR_OFFSET_BITS:  offset_bits  = OFS_W'(value);
            CSR_INDEX_BITS:   index_bits   = IDX_W'(value);
            CSR_WAYS_IN_USE:  ways_in_use  = NWAY_W'(value);
            CSR_WRITE_POLICY: write_policy = POL_W'(value);
            default: ;
         endcase
      endfunction

      // Move one way to rank 0; ways that were more recent age by one.
      function void make_most_recent(int base, int way);
         int old_rank;
         old_rank = line_rank[base + way];
         for (int w = 0; w < WAYS; w++) begin
            if (line_rank[base + w] < old_rank) line_rank[base + w]++;
         end
         line_rank[base + way] = 0;
      endfunction

      // Look up one access, update the shadow store and return its result.
      function result_type lookup_access(logic action, logic [ADDR_W-1:0] addr);
         int         kb, nways, set_no, base, way;
         logic [TAG_W-1:0] tag;
         bit         found, got, evict;
         result_type res;
         kb = 0;
         while (kb < int'(index_bits) && (1 << (kb + 1)) <= SETS) kb++;
         nways = ways_in_use;
         if (nways == 0) nways = 1;
         if (nways > WAYS) nways = WAYS;
         set_no = int'((addr >> offset_bits) & ((32'd1 << kb) - 32'd1));
         tag    = (int'(offset_bits) + kb >= 32) ? '0 : addr >> (int'(offset_bits) + kb);
         base   = set_no * WAYS;
         res    = '0;
         found  = 1'b0;
         way    = 0;

         // The lowest matching way in use wins.
         for (int w = 0; w < nways && !found; w++) begin
            if (line_valid[base + w] && line_tag[base + w] == tag) begin
               found = 1'b1;
               way   = w;
            end
         end

         if (found) begin
            res.hit      = 1'b1;
            res.way_used = WAY_W'(way);
            if (action == ACTION_WRITE) begin
               if (write_policy == POLICY_WRITE_BACK) line_dirty[base + way] = 1'b1;
               else res.memory_refs = 2'd1;
            end
            make_most_recent(base, way);
         end else if (action == ACTION_WRITE && write_policy == POLICY_WRITE_THRU) begin
            // Write miss without allocation goes straight to memory.
            res.memory_refs = 2'd1;
         end else begin
            // Victim: first invalid way in use, else the oldest way in use.
            got = 1'b0;
            for (int w = 0; w < nways && !got; w++) begin
               if (!line_valid[base + w]) begin
                  way = w;
                  got = 1'b1;
               end
            end
            if (!got) begin
               way = 0;
               for (int w = 1; w < nways; w++) begin
                  if (line_rank[base + w] > line_rank[base + way]) way = w;
               end
            end
            evict                 = line_valid[base + way] && line_dirty[base + way];
            res.evicted_dirty     = evict;
            res.memory_refs       = evict ? 2'd2 : 2'd1;
            res.way_used          = WAY_W'(way);
            line_tag[base + way]   = tag;
            line_valid[base + way] = 1'b1;
            line_dirty[base + way] = (action == ACTION_WRITE);
            make_most_recent(base, way);
         end
         return res;
      endfunction

      function void note_access(logic action, logic [ADDR_W-1:0] addr);
         if (action == ACTION_WRITE) writes++;
         else reads++;
         expected_results.push_back(lookup_access(action, addr));
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] data);
         result_type want, got;
         got = result_type'(data[$bits(result_type)-1:0]);
         results_seen++;
         if (got.hit) hits++;
         if (got.evicted_dirty) dirty_evictions++;
         mem_refs += int'(got.memory_refs);
         if (expected_results.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Result beat with no access pending: data %h", data);
            return;
         end
         want = expected_results.pop_front();
         if (got.hit != want.hit || got.memory_refs != want.memory_refs ||
             got.evicted_dirty != want.evicted_dirty || got.way_used != want.way_used ||
             data[RSP_DATA_W-1:$bits(result_type)] != '0) begin
            errors++;
            if (errors <= 10) begin
               $display({"Result %0d mismatch: hit %0d/%0d refs %0d/%0d evd %0d/%0d",
                         " way %0d/%0d pad %h"},
                        results_seen, want.hit, got.hit, want.memory_refs, got.memory_refs,
                        want.evicted_dirty, got.evicted_dirty, want.way_used, got.way_used,
                        data[RSP_DATA_W-1:$bits(result_type)]);
            end
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [ADDR_W-1:0]     req_tdata  = '0;
   logic                  req_tuser  = ACTION_READ;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   tag_store_scoreboard sb = new();
   bit no_idle      = 1'b0;
   int cycle_count  = 0;
   int settings_run = 0;

   set_assoc_lru_cache_tag_store dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Beats are taken from the values present just before each rising edge.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_access(req_tuser, req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding.",
                  cycle_count, sb.expected_results.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Result side: stall a random number of cycles before each beat.
   initial begin
      int gap;
      wait (reset === 1'b0);
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Present one access and hold it until the block takes the beat. Valid is
   // left high so that a following access without a gap goes out back to back.
   task automatic send_access(input logic action, input logic [ADDR_W-1:0] addr);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= addr;
      req_tuser  <= action;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid and wait until every result has come back. The first edge
   // lets the monitor record a beat taken at the edge just passed.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      sb.set_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic set_config(input int ofs, input int idx, input int nways, input int pol);
      write_reg(CSR_OFFSET_BITS, ofs);
      write_reg(CSR_INDEX_BITS, idx);
      write_reg(CSR_WAYS_IN_USE, nways);
      write_reg(CSR_WRITE_POLICY, pol);
      csr_we <= 1'b0;
      settings_run++;
   endtask

   // One setting with random traffic. Most accesses draw their tag from a
   // small pool and their set from a few low sets so that lines hit, age and
   // get evicted; the rest are fully random addresses.
   task automatic run_random_phase(input int ofs, input int idx, input int nways,
                                   input int pol, input int count);
      logic [TAG_W-1:0] tag_pool [8];
      logic [63:0]      addr_wide;
      int               kb, eff_ways, pool_size, nsets, set_no;
      logic             action;
      wait_idle();
      set_config(ofs, idx, nways, pol);
      kb        = (idx > SET_W) ? SET_W : idx;
      eff_ways  = (nways == 0) ? 1 : ((nways > WAYS) ? WAYS : nways);
      pool_size = eff_ways + 2;
      nsets     = 1 << kb;
      for (int k = 0; k < 8; k++) begin
         tag_pool[k] = ($urandom_range(0, 1) == 0) ? TAG_W'(k) : TAG_W'($urandom());
      end
      for (int i = 0; i < count; i++) begin
         if (i % 25 == 0) no_idle = ($urandom_range(0, 2) == 0);
         action = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 99) < 15) begin
            addr_wide = 64'($urandom());
         end else begin
            if ($urandom_range(0, 4) == 0) set_no = $urandom_range(0, nsets - 1);
            else set_no = $urandom_range(0, (nsets > 4) ? 3 : nsets - 1);
            addr_wide = (64'(tag_pool[$urandom_range(0, pool_size - 1)]) << (ofs + kb)) |
                        (64'(set_no) << ofs) |
                        (64'($urandom()) & ((64'd1 << ofs) - 64'd1));
         end
         send_access(action, addr_wide[ADDR_W-1:0]);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings, write-through: fill set 0, hit, write hit and write
      // miss without allocation, LRU eviction, all-ones and top-bit addresses.
      send_access(ACTION_READ,  32'h0000_0000);
      send_access(ACTION_READ,  32'h0000_000F);
      send_access(ACTION_WRITE, 32'h0000_0004);
      send_access(ACTION_WRITE, 32'h0000_0400);
      send_access(ACTION_READ,  32'h0000_0400);
      send_access(ACTION_READ,  32'h0000_0800);
      send_access(ACTION_READ,  32'h0000_0C00);
      send_access(ACTION_READ,  32'h0000_1000);
      send_access(ACTION_READ,  32'hFFFF_FFFF);
      send_access(ACTION_WRITE, 32'hFFFF_FFFF);
      send_access(ACTION_READ,  32'h8000_0000);

      // Write-back: dirty fill, dirty hit, then a dirty line is evicted.
      wait_idle();
      set_config(4, 6, 4, POLICY_WRITE_BACK);
      send_access(ACTION_WRITE, 32'h0000_2000);
      send_access(ACTION_WRITE, 32'h0000_2000);
      send_access(ACTION_READ,  32'h0000_3000);
      send_access(ACTION_READ,  32'h0000_4000);
      send_access(ACTION_READ,  32'h0000_5000);
      send_access(ACTION_READ,  32'h0000_6000);
      send_access(ACTION_WRITE, 32'h0000_7000);

      // Back to write-through: a line left dirty earlier is written back.
      wait_idle();
      set_config(4, 6, 4, POLICY_WRITE_THRU);
      send_access(ACTION_READ, 32'h0000_8000);
      send_access(ACTION_READ, 32'h0000_9000);
      send_access(ACTION_READ, 32'h0000_A000);
      send_access(ACTION_READ, 32'h0000_B000);

      // With one way in use a tag held in a higher way is filled again into
      // way 0; with all ways back in use the lower of the two copies hits.
      wait_idle();
      set_config(4, 6, 1, POLICY_WRITE_THRU);
      send_access(ACTION_READ, 32'h0000_B000);
      wait_idle();
      set_config(4, 6, 4, POLICY_WRITE_THRU);
      send_access(ACTION_READ, 32'h0000_B000);

      // Random traffic across geometries, including saturated and degenerate
      // settings: zero and excess ways, excess index bits, tag shifted out.
      run_random_phase(4,  6, 4, 1, 75);
      run_random_phase(0,  0, 1, 0, 75);
      run_random_phase(16, 6, 4, 1, 75);
      run_random_phase(2,  3, 2, 1, 75);
      run_random_phase(31, 7, 7, 0, 75);
      run_random_phase(8,  2, 0, 1, 75);
      run_random_phase(28, 6, 3, 0, 75);
      run_random_phase(5,  1, 4, 1, 75);
      run_random_phase(0,  6, 5, 0, 75);
      run_random_phase(12, 4, 3, 1, 75);

      // Drain and let the pipeline settle.
      wait_idle();
      repeat (8) @(posedge clock);

      $display("Covered %0d accesses (%0d reads, %0d writes) under %0d register settings.",
               sb.reads + sb.writes, sb.reads, sb.writes, settings_run);
      $display("Results: %0d hits, %0d dirty evictions, %0d memory references, %0d mismatches.",
               sb.hits, sb.dirty_evictions, sb.mem_refs, sb.errors);
      if (sb.errors == 0 && sb.expected_results.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/salru_pkg.sv
sv/set_assoc_lru_cache_tag_store.sv
tb/set_assoc_lru_cache_tag_store_tb.sv
